// ===== rtl/hsa_pkg.sv =====
package hsa_pkg;

	localparam int HANDLE_W   = 8;
	localparam int CNT_W      = 9;
	localparam int IDENT_IO_W = 64;

	typedef enum logic [1:0] {
		CMD_CREATE = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_SET    = 2'd2,
		CMD_GET    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_HANDLE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_LOOKUP,
		S_FINISH
	} state_t;

	typedef struct packed {
		cmd_t                  cmd;
		logic [HANDLE_W-1:0]   handle;
		logic [IDENT_IO_W-1:0] ident_in;
	} req_t;

	typedef struct packed {
		status_t               status;
		logic [HANDLE_W-1:0]   new_handle;
		logic [HANDLE_W-1:0]   dense_slot;
		logic [IDENT_IO_W-1:0] ident_out;
		logic                  ident_present;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic read_a;
		logic read_b;
		logic commit;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_create;
		logic out_free;
	} ctrl_sts_t;

endpackage

// ===== rtl/hsa_ram.sv =====
module hsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/hsa_ctrl.sv =====
module hsa_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  hsa_pkg::ctrl_sts_t    sts,
	output hsa_pkg::ctrl_cmd_t    cmd
);
	hsa_pkg::state_t state_q, state_d;
	logic ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hsa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hsa_pkg::S_IDLE: begin
				if (req_valid) state_d = hsa_pkg::S_READ;
			end
			hsa_pkg::S_READ: begin
				state_d = sts.is_create ? hsa_pkg::S_FINISH : hsa_pkg::S_LOOKUP;
			end
			hsa_pkg::S_LOOKUP: begin
				state_d = hsa_pkg::S_FINISH;
			end
			hsa_pkg::S_FINISH: begin
				if (sts.out_free) begin
					state_d = req_valid ? hsa_pkg::S_READ : hsa_pkg::S_IDLE;
				end
			end
			default: state_d = hsa_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ready       = 1'b0;
		cmd.read_a  = 1'b0;
		cmd.read_b  = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			hsa_pkg::S_IDLE:   ready = 1'b1;
			hsa_pkg::S_READ:   cmd.read_a = 1'b1;
			hsa_pkg::S_LOOKUP: cmd.read_b = 1'b1;
			hsa_pkg::S_FINISH: begin
				// result goes out and the next command comes in on the same edge
				cmd.commit = sts.out_free;
				ready      = sts.out_free;
			end
			default: ready = 1'b0;
		endcase
		cmd.capture = ready & req_valid;
	end

	assign req_stall = !ready;

endmodule

// ===== rtl/hsa_dp.sv =====
module hsa_dp #(
	parameter int LIMIT       = 256,
	parameter int IDENT_WIDTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hsa_pkg::req_t      req,
	input  hsa_pkg::ctrl_cmd_t cmd,
	output hsa_pkg::ctrl_sts_t sts,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output hsa_pkg::rsp_t      rsp
);
	localparam int AW  = $clog2(LIMIT);
	localparam int HW  = hsa_pkg::HANDLE_W;
	localparam int CW  = hsa_pkg::CNT_W;
	localparam int IW1 = IDENT_WIDTH + 1;
	localparam logic [CW-1:0] LIMIT_C = CW'(LIMIT);

	hsa_pkg::cmd_t          cmd_q;
	logic [HW-1:0]          handle_q;
	logic [IDENT_WIDTH-1:0] ident_q;
	logic [HW-1:0]          free_head_q;
	logic [CW-1:0]          live_cnt_q;
	logic [HW-1:0]          moved_q;
	logic [HW-1:0]          slot_q;
	logic                   out_valid_q;
	hsa_pkg::rsp_t          out_q;

	logic [HW-1:0]  nf_rd, soh_rd, hos_rd;
	logic [IW1-1:0] id_rd;

	logic           nf_we, soh_we, hos_we, id_we;
	logic [AW-1:0]  nf_wa, soh_wa, hos_wa, id_wa;
	logic [HW-1:0]  nf_wd, soh_wd, hos_wd;
	logic [IW1-1:0] id_wd;
	logic [AW-1:0]  hos_ra, id_ra;

	logic [CW-1:0]  last;
	logic           h_ok, s_ok, live, full, has_free, do_move;
	logic [HW-1:0]  new_id, new_slot;
	hsa_pkg::rsp_t  rsp_d;
	logic           out_free;

	// ---- input capture and counters ----
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q    <= req.cmd;
			handle_q <= req.handle;
			ident_q  <= req.ident_in[IDENT_WIDTH-1:0];
		end
		if (cmd.read_b) begin
			moved_q <= hos_rd;
			slot_q  <= soh_rd;
		end
		if (cmd.commit) begin
			out_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			live_cnt_q  <= CW'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				unique case (cmd_q)
					hsa_pkg::CMD_CREATE: begin
						if (!full) begin
							live_cnt_q <= live_cnt_q + CW'(1);
							if (has_free) free_head_q <= nf_rd;
						end
					end
					hsa_pkg::CMD_REMOVE: begin
						if (live) begin
							live_cnt_q  <= last;
							free_head_q <= handle_q;
						end
					end
					hsa_pkg::CMD_SET, hsa_pkg::CMD_GET: ;
					default: ;
				endcase
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---- reads: pass one by handle, free head, last slot; pass two by slot ----
	assign last   = live_cnt_q - CW'(1);
	assign hos_ra = cmd.read_a ? last[AW-1:0] : soh_rd[AW-1:0];
	assign id_ra  = (cmd_q == hsa_pkg::CMD_REMOVE) ? last[AW-1:0] : soh_rd[AW-1:0];

	// ---- checks ----
	assign h_ok     = (handle_q != '0) && ({1'b0, handle_q} < LIMIT_C);
	assign s_ok     = (slot_q != '0) && ({1'b0, slot_q} < live_cnt_q);
	assign live     = h_ok && s_ok && (hos_rd == handle_q);
	assign full     = live_cnt_q >= LIMIT_C;
	assign has_free = free_head_q != '0;
	assign new_slot = live_cnt_q[HW-1:0];
	assign new_id   = has_free ? free_head_q : live_cnt_q[HW-1:0];
	assign do_move  = {1'b0, slot_q} < last;

	// ---- commit: writes and result ----
	always_comb begin
		nf_we  = 1'b0;
		soh_we = 1'b0;
		hos_we = 1'b0;
		id_we  = 1'b0;
		nf_wa  = handle_q[AW-1:0];
		nf_wd  = free_head_q;
		soh_wa = new_id[AW-1:0];
		soh_wd = new_slot;
		hos_wa = new_slot[AW-1:0];
		hos_wd = new_id;
		id_wa  = new_slot[AW-1:0];
		id_wd  = '0;
		rsp_d  = '0;
		rsp_d.status = hsa_pkg::ST_OK;
		unique case (cmd_q)
			hsa_pkg::CMD_CREATE: begin
				if (full) begin
					rsp_d.status = hsa_pkg::ST_FULL;
				end else begin
					soh_we           = cmd.commit;
					hos_we           = cmd.commit;
					id_we            = cmd.commit;
					rsp_d.new_handle = new_id;
					rsp_d.dense_slot = new_slot;
				end
			end
			hsa_pkg::CMD_REMOVE: begin
				if (!live) begin
					rsp_d.status = hsa_pkg::ST_BAD_HANDLE;
				end else begin
					nf_we = cmd.commit;
					// last entry fills the hole
					if (do_move) begin
						hos_we = cmd.commit;
						hos_wa = slot_q[AW-1:0];
						hos_wd = moved_q;
						id_we  = cmd.commit;
						id_wa  = slot_q[AW-1:0];
						id_wd  = id_rd;
						soh_we = cmd.commit;
						soh_wa = moved_q[AW-1:0];
						soh_wd = slot_q;
					end
					rsp_d.dense_slot = slot_q;
				end
			end
			hsa_pkg::CMD_SET: begin
				if (!live) begin
					rsp_d.status = hsa_pkg::ST_BAD_HANDLE;
				end else begin
					id_we            = cmd.commit;
					id_wa            = slot_q[AW-1:0];
					id_wd            = {1'b1, ident_q};
					rsp_d.dense_slot = slot_q;
				end
			end
			hsa_pkg::CMD_GET: begin
				if (!live) begin
					rsp_d.status = hsa_pkg::ST_BAD_HANDLE;
				end else begin
					rsp_d.dense_slot = slot_q;
					if (id_rd[IDENT_WIDTH]) begin
						rsp_d.ident_out     = hsa_pkg::IDENT_IO_W'(id_rd[IDENT_WIDTH-1:0]);
						rsp_d.ident_present = 1'b1;
					end
				end
			end
			default: rsp_d.status = hsa_pkg::ST_OK;
		endcase
	end

	hsa_ram #(.WIDTH(HW), .DEPTH(LIMIT)) u_next_free (
		.clk   (clk),
		.we    (nf_we),
		.waddr (nf_wa),
		.wdata (nf_wd),
		.re    (cmd.read_a),
		.raddr (free_head_q[AW-1:0]),
		.rdata (nf_rd)
	);

	hsa_ram #(.WIDTH(HW), .DEPTH(LIMIT)) u_slot_of_handle (
		.clk   (clk),
		.we    (soh_we),
		.waddr (soh_wa),
		.wdata (soh_wd),
		.re    (cmd.read_a),
		.raddr (handle_q[AW-1:0]),
		.rdata (soh_rd)
	);

	hsa_ram #(.WIDTH(HW), .DEPTH(LIMIT)) u_handle_of_slot (
		.clk   (clk),
		.we    (hos_we),
		.waddr (hos_wa),
		.wdata (hos_wd),
		.re    (cmd.read_a | cmd.read_b),
		.raddr (hos_ra),
		.rdata (hos_rd)
	);

	// payload with its present flag on top
	hsa_ram #(.WIDTH(IW1), .DEPTH(LIMIT)) u_ident (
		.clk   (clk),
		.we    (id_we),
		.waddr (id_wa),
		.wdata (id_wd),
		.re    (cmd.read_b),
		.raddr (id_ra),
		.rdata (id_rd)
	);

	assign out_free      = !out_valid_q || !rsp_stall;
	assign sts.out_free  = out_free;
	assign sts.is_create = cmd_q == hsa_pkg::CMD_CREATE;
	assign rsp_valid     = out_valid_q;
	assign rsp           = out_q;

endmodule

// ===== rtl/handle_slot_allocator_core.sv =====
// Slot-map handle allocator: handles 1..min(CAPACITY,256)-1 map to a densely
// packed entry table, handle 0 is null. Each command returns one result on the
// rsp channel. A create passes READ and FINISH before the next transfer;
// remove, set and get also pass LOOKUP, for the two dependent lookups in the
// registered-read tables (handle -> slot, then slot -> owning handle and
// payload). A stalled result holds FINISH until the output register frees.
// After reset the block is ready at once; tables need no clearing.
module handle_slot_allocator_core #(
	parameter int CAPACITY    = 256,
	parameter int IDENT_WIDTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  hsa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output hsa_pkg::rsp_t rsp
);
	localparam int LIMIT = (CAPACITY < 256) ? CAPACITY : 256;

	hsa_pkg::ctrl_cmd_t ctrl_cmd;
	hsa_pkg::ctrl_sts_t ctrl_sts;

	hsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (ctrl_sts),
		.cmd       (ctrl_cmd)
	);

	hsa_dp #(
		.LIMIT       (LIMIT),
		.IDENT_WIDTH (IDENT_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (ctrl_cmd),
		.sts       (ctrl_sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
